### design/rcf_pkg.sv
`default_nettype none
package rcf_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW = $clog2(QueueDepth);
	localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

	localparam logic [7:0] FramePreamble  = 8'h00;
	localparam logic [7:0] FrameStart1    = 8'h00;
	localparam logic [7:0] FrameStart2    = 8'hFF;
	localparam logic [7:0] FramePostamble = 8'h00;
	localparam logic [7:0] DirectionReset = 8'hD4;

	localparam logic [0:0] RegDirection = 1'b0;

	// One classified payload byte, as handed from the front to the back.
	typedef struct packed {
		logic       first;
		logic       last;
		logic [7:0] len;
		logic [7:0] dir;
		logic [7:0] data;
	} rcf_item_t;

	typedef enum logic [3:0] {
		PH_START,
		PH_PRE,
		PH_ST1,
		PH_ST2,
		PH_LEN,
		PH_LCS,
		PH_DIR,
		PH_DATA,
		PH_DCS,
		PH_POST
	} rcf_phase_t;

endpackage
`default_nettype wire

### design/rcf_front.sv
`default_nettype none
module rcf_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          in_byte,
	input  wire  [7:0]          in_count,
	input  wire                 in_last,
	input  wire  [7:0]          dir,
	input  wire                 queue_full,
	output logic                push,
	output rcf_pkg::rcf_item_t  push_item
);
	import rcf_pkg::*;

	logic inside_q;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_item.first = !inside_q;
		push_item.last  = in_last;
		push_item.len   = in_count + 8'd1;
		push_item.dir   = dir;
		push_item.data  = in_byte;
	end

	// A frame is open from its first accepted byte until the byte marked last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (push) begin
			inside_q <= !in_last;
		end
	end

endmodule
`default_nettype wire

### design/rcf_queue.sv
`default_nettype none
module rcf_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  rcf_pkg::rcf_item_t  push_item,
	output logic                full,
	input  wire                 pop,
	output logic                head_valid,
	output rcf_pkg::rcf_item_t  head_item
);
	import rcf_pkg::*;

	rcf_item_t             mem_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueueCntW-1:0]  count_q;

	assign full       = (count_q == QueueCntW'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			case ({push, pop})
				2'b10: begin
					count_q <= count_q + QueueCntW'(1);
				end
				2'b01: begin
					count_q <= count_q - QueueCntW'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### design/rcf_back.sv
`default_nettype none
module rcf_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  rcf_pkg::rcf_item_t  head_item,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last
);
	import rcf_pkg::*;

	rcf_phase_t  phase_q;
	rcf_phase_t  phase_cur;
	rcf_phase_t  phase_next;
	logic [7:0]  sum_q;
	logic [7:0]  byte_cur;
	logic        last_cur;
	logic        load;
	logic        emit;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	assign load = !out_valid_q || out_ready;
	assign emit = head_valid && load;

	// A fresh item starts with the header if it opens a frame, else with its data.
	always_comb begin
		phase_cur = phase_q;
		if (phase_q == PH_START) begin
			phase_cur = head_item.first ? PH_PRE : PH_DATA;
		end
	end

	always_comb begin
		phase_next = phase_cur;
		pop        = 1'b0;
		case (phase_cur)
			PH_PRE: begin
				phase_next = PH_ST1;
			end
			PH_ST1: begin
				phase_next = PH_ST2;
			end
			PH_ST2: begin
				phase_next = PH_LEN;
			end
			PH_LEN: begin
				phase_next = PH_LCS;
			end
			PH_LCS: begin
				phase_next = PH_DIR;
			end
			PH_DIR: begin
				phase_next = PH_DATA;
			end
			PH_DATA: begin
				phase_next = head_item.last ? PH_DCS : PH_START;
				pop        = emit && !head_item.last;
			end
			PH_DCS: begin
				phase_next = PH_POST;
			end
			PH_POST: begin
				phase_next = PH_START;
				pop        = emit;
			end
			default: begin
				phase_next = PH_START;
			end
		endcase
	end

	always_comb begin
		byte_cur = FramePreamble;
		last_cur = 1'b0;
		case (phase_cur)
			PH_PRE: begin
				byte_cur = FramePreamble;
			end
			PH_ST1: begin
				byte_cur = FrameStart1;
			end
			PH_ST2: begin
				byte_cur = FrameStart2;
			end
			PH_LEN: begin
				byte_cur = head_item.len;
			end
			PH_LCS: begin
				byte_cur = 8'd0 - head_item.len;
			end
			PH_DIR: begin
				byte_cur = head_item.dir;
			end
			PH_DATA: begin
				byte_cur = head_item.data;
			end
			PH_DCS: begin
				byte_cur = 8'd0 - sum_q;
			end
			PH_POST: begin
				byte_cur = FramePostamble;
				last_cur = 1'b1;
			end
			default: begin
				byte_cur = FramePreamble;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= phase_next;
				case (phase_cur)
					PH_DIR: begin
						sum_q <= head_item.dir;
					end
					PH_DATA: begin
						sum_q <= sum_q + head_item.data;
					end
					default: begin
						sum_q <= sum_q;
					end
				endcase
			end
			if (load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_cur;
			out_last_q <= last_cur;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

### design/reader_command_framer.sv
`default_nettype none
// Frames command payload bytes into host-to-controller serial frames. The first payload
// byte of a frame is preceded by preamble, start codes, LEN, LCS and the direction byte;
// the byte marked tlast is followed by DCS and the postamble, which carries tlast on the
// output. The front classifies each accepted byte into a four-entry queue and the back
// sequencer emits one frame byte per cycle, unless the queue is empty or the output is
// stalled, into a registered output stage, so payload bytes inside a frame move at one
// transaction per cycle; a frame's first byte holds the sequencer through the header, its
// last through DCS and postamble. Input stalls only once the queue fills. LEN is payload
// count plus one (mod 256) and unchecked; the direction register sits at address 0.
module reader_command_framer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] payload_byte, [15:8] payload_count
	input  wire         s_axis_tlast,   // payload_end
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
	output logic        m_axis_tlast,   // frame_end
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rcf_pkg::*;

	logic       [7:0] dir_q;
	logic             queue_full;
	logic             push;
	rcf_item_t        push_item;
	logic             pop;
	logic             head_valid;
	rcf_item_t        head_item;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DirectionReset;
		end else if (psel && penable && pwrite && pready && (paddr[2] == RegDirection)) begin
			dir_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == RegDirection) begin
			prdata = {24'd0, dir_q};
		end
	end

	rcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata[7:0]),
		.in_count   (s_axis_tdata[15:8]),
		.in_last    (s_axis_tlast),
		.dir        (dir_q),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	rcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	rcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
`default_nettype wire
